### src/frsk_pkg.sv
`default_nettype none

package frsk_pkg;

  // Payload widths.
  localparam int BYTE_W    = 8;
  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 11;
  localparam int COEF_W    = 16;
  localparam int FRAC_W    = 15;
  localparam int DRIFT_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // The widest partial sum is 640 times the sum of the absolute coefficients,
  // which stays below 2^27, so 28 bits hold every sum without overflow.
  localparam int ACC_W = 28;

  localparam int COEF_COUNT = 42;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSERT = 1'b1;

  // Symbol levels.
  localparam logic signed [LEVEL_W-1:0] LEVEL_POS_HI = 11'sd640;
  localparam logic signed [LEVEL_W-1:0] LEVEL_POS_LO = 11'sd213;
  localparam logic signed [LEVEL_W-1:0] LEVEL_NEG_LO = -11'sd213;
  localparam logic signed [LEVEL_W-1:0] LEVEL_NEG_HI = -11'sd640;

  localparam logic [1:0] DIBIT_POS_HI = 2'b11;
  localparam logic [1:0] DIBIT_POS_LO = 2'b10;
  localparam logic [1:0] DIBIT_NEG_LO = 2'b00;

  // State passed from the symbol sequencer to the filter chain.
  typedef struct packed {
    logic                      busy;
    logic                      last;
    logic signed [LEVEL_W-1:0] level;
  } frsk_step_t;

  function automatic logic signed [LEVEL_W-1:0] frsk_level(input logic [1:0] dibit);
    logic signed [LEVEL_W-1:0] lv;
    case (dibit)
      DIBIT_POS_HI: lv = LEVEL_POS_HI;
      DIBIT_POS_LO: lv = LEVEL_POS_LO;
      DIBIT_NEG_LO: lv = LEVEL_NEG_LO;
      default:      lv = LEVEL_NEG_HI;
    endcase
    return lv;
  endfunction

  // Root-raised-cosine taps in Q15; taps past the table are zero.
  function automatic logic signed [COEF_W-1:0] frsk_coef(input int idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      0:  c = 16'sd401;
      1:  c = 16'sd104;
      2:  c = -16'sd340;
      3:  c = -16'sd731;
      4:  c = -16'sd847;
      5:  c = -16'sd553;
      6:  c = 16'sd112;
      7:  c = 16'sd909;
      8:  c = 16'sd1472;
      9:  c = 16'sd1450;
      10: c = 16'sd683;
      11: c = -16'sd675;
      12: c = -16'sd2144;
      13: c = -16'sd3040;
      14: c = -16'sd2706;
      15: c = -16'sd770;
      16: c = 16'sd2667;
      17: c = 16'sd6995;
      18: c = 16'sd11237;
      19: c = 16'sd14331;
      20: c = 16'sd15464;
      21: c = 16'sd14331;
      22: c = 16'sd11237;
      23: c = 16'sd6995;
      24: c = 16'sd2667;
      25: c = -16'sd770;
      26: c = -16'sd2706;
      27: c = -16'sd3040;
      28: c = -16'sd2144;
      29: c = -16'sd675;
      30: c = 16'sd683;
      31: c = 16'sd1450;
      32: c = 16'sd1472;
      33: c = 16'sd909;
      34: c = 16'sd112;
      35: c = -16'sd553;
      36: c = -16'sd847;
      37: c = -16'sd731;
      38: c = -16'sd340;
      39: c = 16'sd104;
      40: c = 16'sd401;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Floor shift by the fraction width, then saturate to the sample width.
  function automatic logic signed [SAMPLE_W-1:0] frsk_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]    sh;
    logic signed [SAMPLE_W-1:0] y;
    sh = acc >>> FRAC_W;
    if ((&sh[ACC_W-1:SAMPLE_W-1]) || !(|sh[ACC_W-1:SAMPLE_W-1])) begin
      y = sh[SAMPLE_W-1:0];
    end else if (sh[ACC_W-1]) begin
      y = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return y;
  endfunction

endpackage

`default_nettype wire

### src/frsk_if.sv
`default_nettype none

interface frsk_byte_if
  import frsk_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface frsk_sample_if
  import frsk_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface frsk_cfg_if
  import frsk_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/fourfsk_rrc_symbol_modulator.sv
// Path: a word accepted on byte_in_i waits in the hold register, moves to the byte
//   register, and its first sample is registered in cell zero for sample_out_o.
// Throughput: one sample per cycle from the single filter chain unless stalled;
//   4*SAMPLES_PER_SYMBOL samples per byte, one more or fewer on drift correction.
// Reset: rst_ni is asynchronous and active low; it clears the filter history,
//   the drift counter, the state and configuration registers and all valid flags.
`default_nettype none

module fourfsk_rrc_symbol_modulator
  import frsk_pkg::*;
#(
  parameter int TAPS               = 42,
  parameter int SAMPLES_PER_SYMBOL = 5
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  frsk_byte_if.sink     byte_in_i,
  frsk_sample_if.source sample_out_o,
  frsk_cfg_if.sink      cfg_i
);

  // Configuration registers. The port never stalls; the user must send writes
  // only while the block is idle, which the block itself does not enforce.
  logic [DRIFT_W-1:0] period_q;
  logic               insert_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      insert_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_PERIOD: period_q <= cfg_i.data[DRIFT_W-1:0];
        CFG_INSERT: insert_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // The sequencer buffers one incoming word, so a new byte is taken while the
  // current one is still being turned into samples.
  frsk_step_t step;
  logic       advance;
  logic       out_valid_q;
  logic       out_last_q;

  // The chain moves on only when a sample can go into the output register,
  // which is the register of the first cell.
  assign advance = step.busy && (!out_valid_q || sample_out_o.ready);

  frsk_seq #(
    .SAMPLES_PER_SYMBOL(SAMPLES_PER_SYMBOL)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_in_i(byte_in_i),
    .advance_i(advance),
    .period_i (period_q),
    .insert_i (insert_q),
    .step_o   (step)
  );

  // Transposed filter: every cell sees the same level, and the partial sums
  // run from the far end of the chain towards cell zero. Cell k weights the
  // level with the tap that applies to a sample k steps old, so the register
  // of cell zero holds the full convolution of the newest sample.
  logic signed [ACC_W-1:0] part [TAPS+1];

  assign part[TAPS] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    frsk_cell #(
      .COEF(frsk_coef(TAPS - 1 - k))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .level_i(step.level),
      .sum_i  (part[k+1]),
      .sum_o  (part[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      out_last_q  <= step.last;
    end else if (sample_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sample_out_o.valid  = out_valid_q;
  assign sample_out_o.last   = out_last_q;
  assign sample_out_o.sample = frsk_sat(part[0]);

endmodule

`default_nettype wire

### src/frsk_cell.sv
`default_nettype none

// One tap of the transposed filter: adds its own product to the partial sum
// handed over by the next cell and passes the result on.
module frsk_cell
  import frsk_pkg::*;
#(
  parameter logic signed [COEF_W-1:0] COEF = '0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic signed [LEVEL_W-1:0] level_i,
  input  wire logic signed [ACC_W-1:0]   sum_i,
  output      logic signed [ACC_W-1:0]   sum_o
);

  logic signed [LEVEL_W+COEF_W-1:0] prod;
  logic signed [ACC_W-1:0]          sum_d;
  logic signed [ACC_W-1:0]          sum_q;

  assign prod  = level_i * COEF;
  assign sum_d = sum_i + ACC_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

### src/frsk_seq.sv
`default_nettype none

// Holds one waiting word, walks the current byte's dibits one sample per step
// and applies the clock drift correction when a byte is loaded.
module frsk_seq
  import frsk_pkg::*;
#(
  parameter int SAMPLES_PER_SYMBOL = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  frsk_byte_if.sink               byte_in_i,
  input  wire logic               advance_i,
  input  wire logic [DRIFT_W-1:0] period_i,
  input  wire logic               insert_i,
  output      frsk_step_t         step_o
);

  localparam int BYTE_SAMPLES = 4 * SAMPLES_PER_SYMBOL;
  localparam int SUB_W = (SAMPLES_PER_SYMBOL > 1) ? $clog2(SAMPLES_PER_SYMBOL) : 1;
  localparam int CNT_W = $clog2(BYTE_SAMPLES + 2);

  logic              hold_valid_q, hold_valid_d;
  logic [BYTE_W-1:0] hold_byte_q;
  logic              busy_q, busy_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [1:0]        sym_q, sym_d;
  logic [SUB_W-1:0]  sub_q, sub_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [DRIFT_W-1:0] drift_q, drift_d;

  logic               is_last;
  logic               load;
  logic [DRIFT_W-1:0] drift_sum;
  logic               correct;
  logic [CNT_W-1:0]   count_new;

  assign is_last = (left_q == CNT_W'(1));
  assign load    = hold_valid_q && (!busy_q || (advance_i && is_last));

  assign byte_in_i.ready = !hold_valid_q;

  // Drift correction, decided once per byte at load time.
  always_comb begin
    drift_sum = drift_q + DRIFT_W'(BYTE_SAMPLES);
    correct   = (period_i != '0) && (drift_sum >= period_i);
    if (period_i == '0) begin
      drift_d = drift_q;
    end else if (correct) begin
      drift_d = drift_sum - period_i;
    end else begin
      drift_d = drift_sum;
    end
    if (!correct) begin
      count_new = CNT_W'(BYTE_SAMPLES);
    end else if (insert_i) begin
      count_new = CNT_W'(BYTE_SAMPLES + 1);
    end else begin
      count_new = CNT_W'(BYTE_SAMPLES - 1);
    end
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    busy_d       = busy_q;
    byte_d       = byte_q;
    sym_d        = sym_q;
    sub_d        = sub_q;
    left_d       = left_q;
    if (load) begin
      hold_valid_d = 1'b0;
    end
    if (byte_in_i.valid && byte_in_i.ready) begin
      hold_valid_d = 1'b1;
    end
    if (load) begin
      busy_d = 1'b1;
      byte_d = hold_byte_q;
      sym_d  = '0;
      sub_d  = '0;
      left_d = count_new;
    end else if (advance_i && busy_q) begin
      left_d = left_q - CNT_W'(1);
      if (is_last) begin
        busy_d = 1'b0;
      end
      if (sub_q == SUB_W'(SAMPLES_PER_SYMBOL - 1)) begin
        sub_d = '0;
        // The final dibit stays put so an inserted sample repeats its level.
        if (sym_q != 2'd3) begin
          sym_d  = sym_q + 2'd1;
          byte_d = {byte_q[BYTE_W-3:0], 2'b00};
        end
      end else begin
        sub_d = sub_q + SUB_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      busy_q       <= 1'b0;
      sym_q        <= '0;
      sub_q        <= '0;
      left_q       <= '0;
      drift_q      <= '0;
    end else begin
      hold_valid_q <= hold_valid_d;
      busy_q       <= busy_d;
      sym_q        <= sym_d;
      sub_q        <= sub_d;
      left_q       <= left_d;
      if (load) begin
        drift_q <= drift_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (byte_in_i.valid && byte_in_i.ready) begin
      hold_byte_q <= byte_in_i.data_byte;
    end
  end

  assign step_o.busy  = busy_q;
  assign step_o.last  = is_last;
  assign step_o.level = frsk_level(byte_q[BYTE_W-1:BYTE_W-2]);

endmodule

`default_nettype wire

### src/frsk_checker.sv
`default_nettype none

module frsk_checker
  import frsk_pkg::*;
(
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [SAMPLE_W-1:0] out_sample,
  input wire logic                       out_last,
  input wire logic                       cfg_ready
);

  // A stalled output word keeps its valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last))
    else $error("output payload changed while stalled");

  // Reset empties the output register at once.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("output valid during reset");

  // The input buffer holds one word, so it is full straight after a take.
  a_in_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while buffer full");

  // Configuration writes are never stalled out of reset.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind fourfsk_rrc_symbol_modulator frsk_checker u_frsk_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (byte_in_i.valid),
  .in_ready  (byte_in_i.ready),
  .out_valid (sample_out_o.valid),
  .out_ready (sample_out_o.ready),
  .out_sample(sample_out_o.sample),
  .out_last  (sample_out_o.last),
  .cfg_ready (cfg_i.ready)
);

`default_nettype wire
